### sv/etmm_pkg.sv
// etmm_pkg: types, polynomial constants and rounding helpers for the
// euler trs model matrix pipeline; no dependencies
`default_nettype none
package etmm_pkg;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [17:0] trig_t;
	typedef logic signed [19:0] rot_t;

	typedef struct packed {
		q16_t pos_x;
		q16_t pos_y;
		q16_t pos_z;
		q16_t scale_x;
		q16_t scale_y;
		q16_t scale_z;
	} side_t;

	localparam int NUM_STAGES = 12;
	localparam int SIN_STAGES = 7;
	localparam int NUM_ROT = 9;

	localparam logic signed [31:0] POLY_A1 = 32'sd1686629713;
	localparam logic signed [31:0] POLY_A3 = -32'sd693598668;
	localparam logic signed [31:0] POLY_A5 = 32'sd85569306;
	localparam logic signed [31:0] POLY_A7 = -32'sd5026995;
	localparam logic signed [31:0] POLY_A9 = 32'sd172272;

	localparam logic [14:0] QUARTER = 15'd16384;
	localparam logic [15:0] QUARTER_BAM = 16'd16384;

	// one horner step: a + round(p * t2 / 2^30)
	function automatic logic signed [32:0] horner_step(
		input logic signed [31:0] a,
		input logic signed [32:0] p,
		input logic signed [31:0] t2
	);
		logic signed [63:0] prod;
		logic signed [63:0] rs;
		prod = 64'(p) * 64'(t2);
		rs = (prod + 64'sd536870912) >>> 30;
		return 33'(rs + 64'(a));
	endfunction

	// round a q32 product to q4.16
	function automatic rot_t rnd_prod(input logic signed [35:0] x);
		logic signed [36:0] t;
		t = 37'(x) + 37'sd32768;
		return rot_t'(t >>> 16);
	endfunction

	// round and saturate scaled entry
	function automatic q16_t sat_q16(input logic signed [51:0] prod);
		logic signed [52:0] v;
		v = (53'(prod) + 53'sd32768) >>> 16;
		if (v > 53'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -53'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return q16_t'(v);
		end
	endfunction

endpackage
`default_nettype wire

### sv/etmm_xform_if.sv
// etmm_xform_if: request channel carrying one transform
// depends on etmm_pkg
`default_nettype none
interface etmm_xform_if;
	import etmm_pkg::*;
	logic valid;
	logic ready;
	q16_t pos_x;
	q16_t pos_y;
	q16_t pos_z;
	logic [15:0] angle_x;
	logic [15:0] angle_y;
	logic [15:0] angle_z;
	q16_t scale_x;
	q16_t scale_y;
	q16_t scale_z;
	modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
		scale_x, scale_y, scale_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
		scale_x, scale_y, scale_z, output ready);
endinterface
`default_nettype wire

### sv/etmm_matrix_if.sv
// etmm_matrix_if: result channel carrying one model matrix
// depends on etmm_pkg
`default_nettype none
interface etmm_matrix_if;
	import etmm_pkg::*;
	logic valid;
	logic ready;
	q16_t m0;
	q16_t m1;
	q16_t m2;
	q16_t m4;
	q16_t m5;
	q16_t m6;
	q16_t m8;
	q16_t m9;
	q16_t m10;
	q16_t trans_x;
	q16_t trans_y;
	q16_t trans_z;
	modport source (output valid, m0, m1, m2, m4, m5, m6, m8, m9, m10,
		trans_x, trans_y, trans_z, input ready);
	modport sink (input valid, m0, m1, m2, m4, m5, m6, m8, m9, m10,
		trans_x, trans_y, trans_z, output ready);
endinterface
`default_nettype wire

### sv/etmm_sin.sv
// etmm_sin: seven stage binary angle sine, quarter wave polynomial
// depends on etmm_pkg
`default_nettype none
module etmm_sin (
	input  wire logic                                clk,
	input  wire logic [etmm_pkg::SIN_STAGES-1:0]     en,
	input  wire logic [15:0]                         angle,
	output etmm_pkg::trig_t                          sin_val
);
	import etmm_pkg::*;

	logic [14:0] u_s1, u_s2, u_s3, u_s4, u_s5, u_s6;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic signed [31:0] t2_s2, t2_s3, t2_s4, t2_s5;
	logic signed [32:0] p_s3, p_s4, p_s5, p_s6;
	trig_t sin_s7;

	logic [14:0] u_in;
	logic [29:0] usq;
	logic signed [63:0] fin_prod;
	logic signed [63:0] fin_v;
	logic signed [63:0] fin_r;
	trig_t fin_c;

	assign u_in = angle[14] ? (QUARTER - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign usq = u_s1 * u_s1;

	always_comb begin
		fin_prod = 64'(p_s6) * 64'($signed({1'b0, u_s6}));
		fin_v = (fin_prod + 64'sd8192) >>> 14;
		fin_r = (fin_v + 64'sd8192) >>> 14;
		if (fin_r < 64'sd0) begin
			fin_c = '0;
		end else if (fin_r > 64'sd65536) begin
			fin_c = 18'sd65536;
		end else begin
			fin_c = trig_t'(fin_r);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			u_s1 <= u_in;
			neg_s1 <= angle[15];
		end
		if (en[1]) begin
			u_s2 <= u_s1;
			neg_s2 <= neg_s1;
			t2_s2 <= $signed({usq, 2'b00});
		end
		if (en[2]) begin
			u_s3 <= u_s2;
			neg_s3 <= neg_s2;
			t2_s3 <= t2_s2;
			p_s3 <= horner_step(POLY_A7, 33'(POLY_A9), t2_s2);
		end
		if (en[3]) begin
			u_s4 <= u_s3;
			neg_s4 <= neg_s3;
			t2_s4 <= t2_s3;
			p_s4 <= horner_step(POLY_A5, p_s3, t2_s3);
		end
		if (en[4]) begin
			u_s5 <= u_s4;
			neg_s5 <= neg_s4;
			t2_s5 <= t2_s4;
			p_s5 <= horner_step(POLY_A3, p_s4, t2_s4);
		end
		if (en[5]) begin
			u_s6 <= u_s5;
			neg_s6 <= neg_s5;
			p_s6 <= horner_step(POLY_A1, p_s5, t2_s5);
		end
		if (en[6]) begin
			sin_s7 <= neg_s6 ? -fin_c : fin_c;
		end
	end

	assign sin_val = sin_s7;

endmodule
`default_nettype wire

### sv/euler_trs_model_matrix_unit.sv
// euler_trs_model_matrix_unit: zyx euler trs model matrix, twelve stage pipeline
// depends on etmm_pkg, etmm_xform_if, etmm_matrix_if, etmm_sin
// throughput: one request per cycle while matrix.ready is high; each stage advances when it is empty or
// the stage after it advances, so a stall only holds full stages
// reset: arst_n clears all stage valid bits; payload registers are not reset
`default_nettype none
module euler_trs_model_matrix_unit (
	input  wire logic      clk,
	input  wire logic      arst_n,
	etmm_xform_if.sink     xform,
	etmm_matrix_if.source  matrix
);
	import etmm_pkg::*;

	logic [NUM_STAGES:1] v_s;
	logic [NUM_STAGES+1:1] rdy;
	side_t side_s [1:NUM_STAGES];

	trig_t sx, cx, sy, cy, sz, cz;

	// stage 8
	logic signed [35:0] czcy_s8, szcy_s8, cysx_s8, cycx_s8, czsy_s8, szsy_s8;
	logic signed [35:0] szcx_s8, szsx_s8, czcx_s8, czsx_s8;
	trig_t sx_s8, cx_s8, nsy_s8;
	// stage 9
	logic signed [53:0] t1_s9, t2_s9, t5_s9, t6_s9;
	logic signed [35:0] szcx_s9, szsx_s9, czcx_s9, czsx_s9;
	rot_t r0_s9, r4_s9, r8_s9, r9_s9, r10_s9;
	// stage 10 to 12
	rot_t rot_s10 [NUM_ROT];
	logic signed [51:0] prod_s11 [NUM_ROT];
	q16_t ent_s12 [NUM_ROT];

	logic signed [55:0] sum1, sum2, sum5, sum6;

	always_comb begin
		rdy[NUM_STAGES+1] = matrix.ready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	assign xform.ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (rdy[1]) begin
				v_s[1] <= xform.valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (rdy[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			side_s[1] <= '{xform.pos_x, xform.pos_y, xform.pos_z,
				xform.scale_x, xform.scale_y, xform.scale_z};
		end
		for (int k = 2; k <= NUM_STAGES; k++) begin
			if (rdy[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	etmm_sin u_sx (.clk, .en(rdy[SIN_STAGES:1]), .angle(xform.angle_x),
		.sin_val(sx));
	etmm_sin u_cx (.clk, .en(rdy[SIN_STAGES:1]),
		.angle(16'(xform.angle_x + QUARTER_BAM)), .sin_val(cx));
	etmm_sin u_sy (.clk, .en(rdy[SIN_STAGES:1]), .angle(xform.angle_y),
		.sin_val(sy));
	etmm_sin u_cy (.clk, .en(rdy[SIN_STAGES:1]),
		.angle(16'(xform.angle_y + QUARTER_BAM)), .sin_val(cy));
	etmm_sin u_sz (.clk, .en(rdy[SIN_STAGES:1]), .angle(xform.angle_z),
		.sin_val(sz));
	etmm_sin u_cz (.clk, .en(rdy[SIN_STAGES:1]),
		.angle(16'(xform.angle_z + QUARTER_BAM)), .sin_val(cz));

	always_comb begin
		sum1 = 56'(t1_s9) - (56'(szcx_s9) <<< 16) + 56'sd2147483648;
		sum2 = 56'(t2_s9) + (56'(szsx_s9) <<< 16) + 56'sd2147483648;
		sum5 = 56'(t5_s9) + (56'(czcx_s9) <<< 16) + 56'sd2147483648;
		sum6 = 56'(t6_s9) - (56'(czsx_s9) <<< 16) + 56'sd2147483648;
	end

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			czcy_s8 <= 36'(cz) * 36'(cy);
			szcy_s8 <= 36'(sz) * 36'(cy);
			cysx_s8 <= 36'(cy) * 36'(sx);
			cycx_s8 <= 36'(cy) * 36'(cx);
			czsy_s8 <= 36'(cz) * 36'(sy);
			szsy_s8 <= 36'(sz) * 36'(sy);
			szcx_s8 <= 36'(sz) * 36'(cx);
			szsx_s8 <= 36'(sz) * 36'(sx);
			czcx_s8 <= 36'(cz) * 36'(cx);
			czsx_s8 <= 36'(cz) * 36'(sx);
			sx_s8 <= sx;
			cx_s8 <= cx;
			nsy_s8 <= -sy;
		end
		if (rdy[9]) begin
			t1_s9 <= 54'(czsy_s8) * 54'(sx_s8);
			t2_s9 <= 54'(czsy_s8) * 54'(cx_s8);
			t5_s9 <= 54'(szsy_s8) * 54'(sx_s8);
			t6_s9 <= 54'(szsy_s8) * 54'(cx_s8);
			szcx_s9 <= szcx_s8;
			szsx_s9 <= szsx_s8;
			czcx_s9 <= czcx_s8;
			czsx_s9 <= czsx_s8;
			r0_s9 <= rnd_prod(czcy_s8);
			r4_s9 <= rnd_prod(szcy_s8);
			r8_s9 <= rot_t'(nsy_s8);
			r9_s9 <= rnd_prod(cysx_s8);
			r10_s9 <= rnd_prod(cycx_s8);
		end
		if (rdy[10]) begin
			rot_s10[0] <= r0_s9;
			rot_s10[1] <= rot_t'(sum1 >>> 32);
			rot_s10[2] <= rot_t'(sum2 >>> 32);
			rot_s10[3] <= r4_s9;
			rot_s10[4] <= rot_t'(sum5 >>> 32);
			rot_s10[5] <= rot_t'(sum6 >>> 32);
			rot_s10[6] <= r8_s9;
			rot_s10[7] <= r9_s9;
			rot_s10[8] <= r10_s9;
		end
		if (rdy[11]) begin
			for (int i = 0; i < 3; i++) begin
				prod_s11[i] <= 52'(rot_s10[i]) * 52'(side_s[10].scale_x);
				prod_s11[i+3] <= 52'(rot_s10[i+3]) * 52'(side_s[10].scale_y);
				prod_s11[i+6] <= 52'(rot_s10[i+6]) * 52'(side_s[10].scale_z);
			end
		end
		if (rdy[12]) begin
			for (int i = 0; i < NUM_ROT; i++) begin
				ent_s12[i] <= sat_q16(prod_s11[i]);
			end
		end
	end

	assign matrix.valid = v_s[NUM_STAGES];
	assign matrix.m0 = ent_s12[0];
	assign matrix.m1 = ent_s12[1];
	assign matrix.m2 = ent_s12[2];
	assign matrix.m4 = ent_s12[3];
	assign matrix.m5 = ent_s12[4];
	assign matrix.m6 = ent_s12[5];
	assign matrix.m8 = ent_s12[6];
	assign matrix.m9 = ent_s12[7];
	assign matrix.m10 = ent_s12[8];
	assign matrix.trans_x = side_s[NUM_STAGES].pos_x;
	assign matrix.trans_y = side_s[NUM_STAGES].pos_y;
	assign matrix.trans_z = side_s[NUM_STAGES].pos_z;

endmodule
`default_nettype wire

### sv/etmm_checker.sv
// etmm_checker: port level assertions for euler_trs_model_matrix_unit, with bind
// depends on etmm_pkg, etmm_xform_if, etmm_matrix_if
`default_nettype none
module etmm_checker (
	input  wire logic     clk,
	input  wire logic     arst_n,
	etmm_xform_if.sink    xform,
	etmm_matrix_if.source matrix
);
	import etmm_pkg::*;

	logic [3:0] occ_q;
	logic [3:0] age_q;
	logic in_acc;
	logic out_acc;

	assign in_acc = xform.valid && xform.ready;
	assign out_acc = matrix.valid && matrix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			age_q <= '0;
		end else begin
			occ_q <= 4'(occ_q + {3'b000, in_acc} - {3'b000, out_acc});
			if (age_q != 4'(NUM_STAGES + 1)) begin
				age_q <= 4'(age_q + 4'd1);
			end
		end
	end

	// requests in flight never exceed the pipeline depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 4'(NUM_STAGES))
		else $error("more requests in flight than stages");

	// no result without a pending request
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid |-> occ_q != 4'd0)
		else $error("result with no pending request");

	// with the sink always ready, a request comes out with its translation unchanged
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(age_q == 4'(NUM_STAGES + 1)) && $past(in_acc, 12)
		&& $past(matrix.ready, 1) && $past(matrix.ready, 2) && $past(matrix.ready, 3)
		&& $past(matrix.ready, 4) && $past(matrix.ready, 5) && $past(matrix.ready, 6)
		&& $past(matrix.ready, 7) && $past(matrix.ready, 8) && $past(matrix.ready, 9)
		&& $past(matrix.ready, 10) && $past(matrix.ready, 11)
		|-> matrix.valid && matrix.trans_x == $past(xform.pos_x, 12)
		&& matrix.trans_z == $past(xform.pos_z, 12))
		else $error("result latency or translation mismatch");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid && !matrix.ready |=> matrix.valid && $stable(matrix.m0)
		&& $stable(matrix.m5) && $stable(matrix.m10) && $stable(matrix.trans_y))
		else $error("stalled result changed");

endmodule

bind euler_trs_model_matrix_unit etmm_checker u_etmm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.xform(xform),
	.matrix(matrix)
);
`default_nettype wire
